// ----- src/smt_pkg.sv -----
// Package: shared types, constants and helpers for the sparse matrix transpose.
`timescale 1ns / 1ps
package smt_pkg;

	localparam int MAX_ROWS_DEF    = 256;
	localparam int MAX_COLS_DEF    = 256;
	localparam int MAX_ENTRIES_DEF = 1024;
	localparam int VALUE_WIDTH_DEF = 32;

	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_FETCH = 1'b1;

	localparam logic REG_ROW_COUNT    = 1'b0;
	localparam logic REG_COLUMN_COUNT = 1'b1;

	typedef struct packed {
		logic               command;
		logic [8:0]         src_row;
		logic [8:0]         src_col;
		logic signed [31:0] value;
	} in_word_t;

	typedef struct packed {
		logic [8:0]         dst_row;
		logic [10:0]        dst_row_count;
		logic [8:0]         dst_col;
		logic signed [31:0] out_value;
		logic               row_empty;
		logic               last_in_row;
		logic               last_of_matrix;
		logic               entries_dropped;
	} out_word_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOAD_WR,
		ST_PFX_RD,
		ST_PFX_WR,
		ST_SCT_RD,
		ST_SCT_FILL,
		ST_SCT_WR,
		ST_EMIT_RD,
		ST_EMIT_OUT
	} state_t;

	// register value of 0 means 1, above the maximum means the maximum
	function automatic int clamp_count(input logic [8:0] r, input int maxv);
		int v;
		v = int'(r);
		if (v == 0)
			return 1;
		if (v > maxv)
			return maxv;
		return v;
	endfunction

endpackage

// ----- src/smt_ram.sv -----
// Simple dual-port synchronous RAM with registered read data.
`timescale 1ns / 1ps
module smt_ram #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata <= mem[raddr];
	end
endmodule

// ----- src/sparse_matrix_transpose.sv -----
// Top level: sparse matrix transpose, row-ordered entries in, transposed entries out.
// Load: a rejected entry is dropped in ST_IDLE; a stored one also passes ST_LOAD_WR
// (read-modify-write of the column count RAM). Fetch: result passes ST_EMIT_RD and ST_EMIT_OUT;
// input waits until it is taken. First fetch of a matrix first runs placement: prefix sums over
// all MAX_COLS columns, then ST_SCT_RD, ST_SCT_FILL and ST_SCT_WR per stored entry for the scatter.
// Reset and matrix end clear all MAX_COLS words of the count RAM; config resets to 1 x 1.
`timescale 1ns / 1ps
module sparse_matrix_transpose #(
	parameter int MAX_ROWS    = smt_pkg::MAX_ROWS_DEF,
	parameter int MAX_COLS    = smt_pkg::MAX_COLS_DEF,
	parameter int MAX_ENTRIES = smt_pkg::MAX_ENTRIES_DEF,
	parameter int VALUE_WIDTH = smt_pkg::VALUE_WIDTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  smt_pkg::in_word_t in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output smt_pkg::out_word_t out_data,
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [8:0]        cfg_data
);
	import smt_pkg::*;

	localparam int RW  = $clog2(MAX_ROWS + 1);
	localparam int CLW = $clog2(MAX_COLS + 1);
	localparam int CAW = $clog2(MAX_COLS);
	localparam int AW  = $clog2(MAX_ENTRIES);
	localparam int CW  = $clog2(MAX_ENTRIES + 1);
	localparam int EW  = RW + CLW + VALUE_WIDTH;
	localparam int TW  = RW + VALUE_WIDTH;

	state_t state_q, state_d;

	logic [8:0]       row_count_q, column_count_q;
	logic [CW-1:0]    total_q;
	logic [RW-1:0]    last_row_q;
	logic             drop_q;
	logic             emitting_q;
	logic [CAW-1:0]   clr_q;
	logic [CAW-1:0]   pcol_q;
	logic [CW-1:0]    sum_q;
	logic [CW-1:0]    sidx_q;
	logic [CLW-1:0]   col_q;
	logic [CW-1:0]    pos_q;
	logic [CW-1:0]    ptr_q;
	logic [CLW-1:0]   latched_q;
	logic [CAW-1:0]   ldcol_q;
	logic             out_valid_q;
	out_word_t        out_q;

	// RAM ports
	logic             ent_we, ent_re;
	logic [AW-1:0]    ent_waddr, ent_raddr;
	logic [EW-1:0]    ent_wdata, ent_rdata;
	logic             tr_we, tr_re;
	logic [AW-1:0]    tr_waddr, tr_raddr;
	logic [TW-1:0]    tr_wdata, tr_rdata;
	logic             cnt_we, cnt_re;
	logic [CAW-1:0]   cnt_waddr, cnt_raddr;
	logic [CW-1:0]    cnt_wdata, cnt_rdata;
	logic             fil_we, fil_re;
	logic [CAW-1:0]   fil_waddr, fil_raddr;
	logic [CW-1:0]    fil_wdata, fil_rdata;

	logic             accept, is_fetch, load_ok;
	int               rows_i, cols_i;
	logic [CLW-1:0]   ent_col;
	logic [RW-1:0]    ent_row;
	logic             em_empty, em_last_row, em_last_mat;

	assign in_ready  = (state_q == ST_IDLE) && !out_valid_q;
	assign accept    = in_valid && in_ready;
	assign is_fetch  = (in_data.command == CMD_FETCH);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_comb begin
		rows_i  = clamp_count(row_count_q, MAX_ROWS);
		cols_i  = clamp_count(column_count_q, MAX_COLS);
		load_ok = !emitting_q
			&& (in_data.src_row != 9'd0) && (int'(in_data.src_row) <= rows_i)
			&& (in_data.src_col != 9'd0) && (int'(in_data.src_col) <= cols_i)
			&& (int'(in_data.src_row) >= int'(last_row_q))
			&& (int'(total_q) < MAX_ENTRIES);
	end

	assign ent_row = ent_rdata[EW-1 -: RW];
	assign ent_col = ent_rdata[VALUE_WIDTH +: CLW];

	always_comb begin
		em_empty    = (cnt_rdata == '0);
		em_last_row = em_empty || ((pos_q + CW'(1)) >= cnt_rdata);
		em_last_mat = em_last_row && ((32'(col_q) + 32'd1) >= 32'(latched_q));
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR:    if (clr_q == CAW'(MAX_COLS - 1)) state_d = ST_IDLE;
			ST_IDLE: begin
				if (accept) begin
					if (is_fetch)
						state_d = emitting_q ? ST_EMIT_RD : ST_PFX_RD;
					else if (load_ok)
						state_d = ST_LOAD_WR;
				end
			end
			ST_LOAD_WR:  state_d = ST_IDLE;
			ST_PFX_RD:   state_d = ST_PFX_WR;
			ST_PFX_WR: begin
				if (pcol_q != CAW'(MAX_COLS - 1))
					state_d = ST_PFX_RD;
				else if (total_q == '0)
					state_d = ST_EMIT_RD;
				else
					state_d = ST_SCT_RD;
			end
			ST_SCT_RD:   state_d = ST_SCT_FILL;
			ST_SCT_FILL: state_d = ST_SCT_WR;
			ST_SCT_WR:   state_d = ((sidx_q + CW'(1)) == total_q) ? ST_EMIT_RD : ST_SCT_RD;
			ST_EMIT_RD:  state_d = ST_EMIT_OUT;
			ST_EMIT_OUT: state_d = em_last_mat ? ST_CLEAR : ST_IDLE;
			default:     state_d = ST_CLEAR;
		endcase
	end

	// memory controls
	always_comb begin
		ent_we    = 1'b0;
		ent_waddr = total_q[AW-1:0];
		ent_wdata = {RW'(in_data.src_row), CLW'(in_data.src_col),
			VALUE_WIDTH'($unsigned(in_data.value))};
		ent_re    = 1'b0;
		ent_raddr = sidx_q[AW-1:0];
		tr_we     = 1'b0;
		tr_waddr  = fil_rdata[AW-1:0];
		tr_wdata  = {ent_row, ent_rdata[VALUE_WIDTH-1:0]};
		tr_re     = 1'b0;
		tr_raddr  = ptr_q[AW-1:0];
		cnt_we    = 1'b0;
		cnt_waddr = clr_q;
		cnt_wdata = '0;
		cnt_re    = 1'b0;
		cnt_raddr = CAW'(in_data.src_col - 9'd1);
		fil_we    = 1'b0;
		fil_waddr = pcol_q;
		fil_wdata = sum_q;
		fil_re    = 1'b0;
		fil_raddr = CAW'(ent_col - CLW'(1));
		case (state_q)
			ST_CLEAR: cnt_we = 1'b1;
			ST_IDLE: begin
				if (accept && !is_fetch && load_ok) begin
					ent_we = 1'b1;
					cnt_re = 1'b1;
				end
			end
			ST_LOAD_WR: begin
				cnt_we    = 1'b1;
				cnt_waddr = ldcol_q;
				cnt_wdata = cnt_rdata + CW'(1);
			end
			ST_PFX_RD: begin
				cnt_re    = 1'b1;
				cnt_raddr = pcol_q;
			end
			ST_PFX_WR:   fil_we = 1'b1;
			ST_SCT_RD:   ent_re = 1'b1;
			ST_SCT_FILL: fil_re = 1'b1;
			ST_SCT_WR: begin
				tr_we     = 1'b1;
				fil_we    = 1'b1;
				fil_waddr = fil_raddr;
				fil_wdata = fil_rdata + CW'(1);
			end
			ST_EMIT_RD: begin
				cnt_re    = 1'b1;
				cnt_raddr = CAW'(col_q);
				tr_re     = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_CLEAR;
			row_count_q    <= 9'd1;
			column_count_q <= 9'd1;
			total_q        <= '0;
			last_row_q     <= '0;
			drop_q         <= 1'b0;
			emitting_q     <= 1'b0;
			clr_q          <= '0;
			pcol_q         <= '0;
			sum_q          <= '0;
			sidx_q         <= '0;
			col_q          <= '0;
			pos_q          <= '0;
			ptr_q          <= '0;
			latched_q      <= CLW'(1);
			ldcol_q        <= '0;
			out_valid_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				if (cfg_index == REG_ROW_COUNT)
					row_count_q <= cfg_data;
				else
					column_count_q <= cfg_data;
			end
			if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_CLEAR: clr_q <= clr_q + CAW'(1);
				ST_IDLE: begin
					if (accept) begin
						if (is_fetch) begin
							pcol_q <= '0;
							sum_q  <= '0;
						end else if (load_ok) begin
							total_q    <= total_q + CW'(1);
							last_row_q <= RW'(in_data.src_row);
							ldcol_q    <= CAW'(in_data.src_col - 9'd1);
						end else begin
							drop_q <= 1'b1;
						end
					end
				end
				ST_PFX_WR: begin
					sum_q  <= sum_q + cnt_rdata;
					pcol_q <= pcol_q + CAW'(1);
					sidx_q <= '0;
					if (pcol_q == CAW'(MAX_COLS - 1) && total_q == '0) begin
						emitting_q <= 1'b1;
						latched_q  <= CLW'(cols_i);
						col_q      <= '0;
						pos_q      <= '0;
						ptr_q      <= '0;
					end
				end
				ST_SCT_WR: begin
					sidx_q <= sidx_q + CW'(1);
					if ((sidx_q + CW'(1)) == total_q) begin
						emitting_q <= 1'b1;
						latched_q  <= CLW'(cols_i);
						col_q      <= '0;
						pos_q      <= '0;
						ptr_q      <= '0;
					end
				end
				ST_EMIT_OUT: begin
					out_valid_q <= 1'b1;
					if (em_last_mat) begin
						// matrix done, start over
						total_q    <= '0;
						last_row_q <= '0;
						drop_q     <= 1'b0;
						emitting_q <= 1'b0;
						clr_q      <= '0;
						col_q      <= '0;
						pos_q      <= '0;
						ptr_q      <= '0;
					end else begin
						if (em_last_row) begin
							col_q <= col_q + CLW'(1);
							pos_q <= '0;
						end else begin
							pos_q <= pos_q + CW'(1);
						end
						if (!em_empty)
							ptr_q <= ptr_q + CW'(1);
					end
				end
				default: ;
			endcase
		end
	end

	// result word, no reset needed
	always_ff @(posedge clk) begin
		if (state_q == ST_EMIT_OUT) begin
			out_q.dst_row         <= 9'(col_q + CLW'(1));
			out_q.dst_row_count   <= 11'(cnt_rdata);
			out_q.dst_col         <= em_empty ? 9'd0 : 9'(tr_rdata[TW-1 -: RW]);
			out_q.out_value       <= em_empty ? 32'sd0 : 32'(tr_rdata[VALUE_WIDTH-1:0]);
			out_q.row_empty       <= em_empty;
			out_q.last_in_row     <= em_last_row;
			out_q.last_of_matrix  <= em_last_mat;
			out_q.entries_dropped <= drop_q;
		end
	end

	smt_ram #(.DEPTH(MAX_ENTRIES), .WIDTH(EW)) u_entry_ram (
		.clk(clk), .we(ent_we), .waddr(ent_waddr), .wdata(ent_wdata),
		.re(ent_re), .raddr(ent_raddr), .rdata(ent_rdata)
	);

	smt_ram #(.DEPTH(MAX_ENTRIES), .WIDTH(TW)) u_trans_ram (
		.clk(clk), .we(tr_we), .waddr(tr_waddr), .wdata(tr_wdata),
		.re(tr_re), .raddr(tr_raddr), .rdata(tr_rdata)
	);

	smt_ram #(.DEPTH(MAX_COLS), .WIDTH(CW)) u_count_ram (
		.clk(clk), .we(cnt_we), .waddr(cnt_waddr), .wdata(cnt_wdata),
		.re(cnt_re), .raddr(cnt_raddr), .rdata(cnt_rdata)
	);

	// column start offsets, bumped per entry during the scatter
	smt_ram #(.DEPTH(MAX_COLS), .WIDTH(CW)) u_fill_ram (
		.clk(clk), .we(fil_we), .waddr(fil_waddr), .wdata(fil_wdata),
		.re(fil_re), .raddr(fil_raddr), .rdata(fil_rdata)
	);
endmodule
